@@ design/rsa_block_modexp_macros.svh @@
// assertion macros shared by the modular exponentiation block
`ifndef RSA_BLOCK_MODEXP_MACROS_SVH
`define RSA_BLOCK_MODEXP_MACROS_SVH
// assert that a condition holds at every edge outside reset
`define RBM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// assert that a consequent holds in the cycle after an antecedent
`define RBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/rbm_pkg.sv @@
// shared constants of the modular exponentiation block
`timescale 1ns / 1ps
package rbm_pkg;
  localparam int DataWidth = 31;
  localparam int CntWidth = 5;
  localparam logic [0:0] RegExponent = 1'd0;
  localparam logic [0:0] RegModulus = 1'd1;
  localparam int TdataWidth = 32;
endpackage

@@ design/rbm_cell.sv @@
// one bit slice of the bit-serial modular multiplier
`timescale 1ns / 1ps
module rbm_cell (
  input  logic clk,
  input  logic clear,
  input  logic shift,
  input  logic lower_in,
  input  logic a_bit,
  input  logic m_bit,
  input  logic borrow_in,
  input  logic next_bit,
  input  logic add_en,
  input  logic carry_in,
  output logic carry_out,
  output logic borrow_out,
  output logic r_bit,
  output logic d_bit
);
  logic r;
  logic t;
  // operand added at this slice
  assign t = add_en & a_bit;
  // sum bit of shifted remainder plus multiplicand
  assign d_bit = lower_in ^ t ^ carry_in;
  assign carry_out = (lower_in & t) | (lower_in & carry_in) | (t & carry_in);
  // borrow of the sum minus twice the modulus
  assign borrow_out = (~d_bit & (m_bit | borrow_in)) | (m_bit & borrow_in);
  assign r_bit = r;
  // remainder register of this slice
  always_ff @(posedge clk) begin
    if (clear) begin
      r <= 1'b0;
    end else if (shift) begin
      r <= next_bit;
    end
  end
endmodule

@@ design/rbm_mulmod.sv @@
// bit-serial interleaved modular multiplier built from a row of cells
`timescale 1ns / 1ps
module rbm_mulmod (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rbm_pkg::DataWidth-1:0] a,
  input  logic [rbm_pkg::DataWidth-1:0] b,
  input  logic [rbm_pkg::DataWidth-1:0] m,
  output logic done,
  output logic [rbm_pkg::DataWidth-1:0] p
);
  localparam int W = rbm_pkg::DataWidth;
  // cells cover the remainder plus two guard bits
  localparam int N = W + 2;
  logic [W-1:0] bsh;
  logic [rbm_pkg::CntWidth-1:0] cnt;
  logic busy;
  logic [N-1:0] r_q;
  logic [N-1:0] lower, d, aw, mw, nw;
  logic [N:0] c, s1;
  logic [N-1:0] dd, d2;
  logic ge2, ge1;
  // shifted remainder and operand words
  assign lower = {r_q[N-2:0], 1'b0};
  assign aw = {2'b00, a};
  assign mw = {2'b00, m};
  assign nw = {1'b0, m, 1'b0};
  assign c[0] = 1'b0;
  assign s1[0] = 1'b0;
  // row of cells: add chain, compare against 2m, remainder bits
  genvar g;
  for (g = 0; g < N; g++) begin : g_cell
    logic rb, db;
    rbm_cell u_cell (
      .clk(clk), .clear(start), .shift(busy), .lower_in(lower[g]),
      .a_bit(aw[g]), .m_bit(nw[g]), .borrow_in(s1[g]), .next_bit(d2[g]),
      .add_en(bsh[W-1]), .carry_in(c[g]), .carry_out(c[g+1]),
      .borrow_out(s1[g+1]), .r_bit(rb), .d_bit(db)
    );
    assign d[g] = db;
    assign r_q[g] = rb;
  end
  // reduce by 2m, then by m
  assign ge2 = c[N] | ~s1[N];
  assign dd = ge2 ? d - nw : d;
  assign ge1 = dd >= mw;
  assign d2 = ge1 ? dd - mw : dd;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rbm_pkg::CntWidth'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  // multiplier bits, most significant first
  always_ff @(posedge clk) begin
    if (start) begin
      bsh <= b;
    end else if (busy) begin
      bsh <= {bsh[W-2:0], 1'b0};
    end
  end
  assign p = r_q[W-1:0];
  `include "rsa_block_modexp_macros.svh"
  `RBM_ASSERT_NEXT(a_done_ends, done, !busy, "multiplier busy after done")
  `RBM_ASSERT_ALWAYS(a_rem_lt, !busy || (r_q < mw) || (m == '0), "remainder not reduced")
  `RBM_ASSERT_NEXT(a_start_busy, start, busy, "start did not launch")
endmodule

@@ design/rsa_block_modexp.sv @@
// top level of the modular exponentiation block
// Each word takes 32 + (set bits of exponent) multiplications, 32 to 63, all on
// one shared bit-serial multiplier (a row of 33 cells); a word is taken only
// when the previous cipher has left the output register. Results are
// message_block ^ exponent mod modulus, and 0 for a modulus below two.
`timescale 1ns / 1ps
module rsa_block_modexp (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [0:0] wr_index,
  input  logic [rbm_pkg::DataWidth-1:0] wr_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [rbm_pkg::TdataWidth-1:0] s_tdata, // message_block, pad
  output logic m_tvalid,
  input  logic m_tready,
  output logic [rbm_pkg::TdataWidth-1:0] m_tdata  // cipher_block, pad
);
  localparam int W = rbm_pkg::DataWidth;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed = 3'd1;
  localparam logic [2:0] StMul = 3'd2;
  localparam logic [2:0] StSq = 3'd3;
  localparam logic [2:0] StOut = 3'd4;
  logic [2:0] state;
  logic [W-1:0] exponent, modulus, base, acc, esh, ma, mb;
  logic [rbm_pkg::CntWidth-1:0] bit_cnt;
  logic mul_start;
  logic mul_done;
  logic [W-1:0] prod;
  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= W'(1);
      modulus <= W'(2);
    end else if (wr_en) begin
      if (wr_index == rbm_pkg::RegExponent) exponent <= wr_data;
      if (wr_index == rbm_pkg::RegModulus) modulus <= wr_data;
    end
  end
  rbm_mulmod u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(ma), .b(mb), .m(modulus),
    .done(mul_done), .p(prod)
  );
  assign s_tready = (state == StIdle);
  assign m_tvalid = (state == StOut);
  assign m_tdata = {1'b0, acc};
  // sequencer: reduce base (1*message), then per exponent bit multiply and square
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      mul_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      case (state)
        StIdle: begin
          if (s_tvalid) begin
            ma <= W'(1);
            mb <= s_tdata[W-1:0];
            esh <= exponent;
            bit_cnt <= '0;
            acc <= (modulus < W'(2)) ? '0 : W'(1);
            mul_start <= 1'b1;
            state <= StRed;
          end
        end
        StRed: begin
          if (mul_done) begin
            base <= prod;
            ma <= acc;
            mb <= prod;
            mul_start <= esh[0];
            state <= esh[0] ? StMul : StSq;
            if (!esh[0]) begin
              ma <= prod;
              mul_start <= 1'b1;
            end
          end
        end
        StMul: begin
          if (mul_done) begin
            acc <= (modulus < W'(2)) ? '0 : prod;
            ma <= base;
            mb <= base;
            mul_start <= 1'b1;
            state <= StSq;
          end
        end
        StSq: begin
          if (mul_done) begin
            base <= prod;
            esh <= {1'b0, esh[W-1:1]};
            bit_cnt <= bit_cnt + 1'b1;
            if (bit_cnt == rbm_pkg::CntWidth'(W - 1)) begin
              state <= StOut;
            end else if (esh[1]) begin
              ma <= acc;
              mb <= prod;
              mul_start <= 1'b1;
              state <= StMul;
            end else begin
              ma <= prod;
              mb <= prod;
              mul_start <= 1'b1;
            end
          end
        end
        StOut: begin
          if (m_tready) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
  `include "rsa_block_modexp_macros.svh"
  `RBM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "dropped")
  `RBM_ASSERT_ALWAYS(a_acc_lt, !m_tvalid || acc < modulus || modulus < W'(2), "cipher not reduced")
  `RBM_ASSERT_NEXT(a_take, s_tvalid && s_tready, !s_tready, "accepted while busy")
endmodule

@@ dv/rbm_cipher_checker.sv @@
// checker for the modular exponentiation block: predicts and compares cipher words
`timescale 1ns / 1ps
module rbm_cipher_checker (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [0:0] wr_index,
  input  logic [rbm_pkg::DataWidth-1:0] wr_data,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [rbm_pkg::TdataWidth-1:0] s_tdata, // message_block, pad
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [rbm_pkg::TdataWidth-1:0] m_tdata, // cipher_block, pad
  output int   fails,
  output int   pending
);
  localparam int W = rbm_pkg::DataWidth;

  logic [W-1:0] exp_reg;
  logic [W-1:0] mod_reg;
  logic [W-1:0] cipher_q[$];

  // right-to-left square and multiply over all exponent bits
  function automatic logic [W-1:0] mod_power(logic [W-1:0] base,
                                             logic [W-1:0] e,
                                             logic [W-1:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    if (m < 2) return '0;
    acc = 64'd1;
    b = 64'(base) % 64'(m);
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * b) % 64'(m);
      b = (b * b) % 64'(m);
    end
    return acc[W-1:0];
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    if (rst) begin
      exp_reg <= W'(1);
      mod_reg <= W'(2);
      cipher_q.delete();
    end else begin
      // register writes
      if (wr_en) begin
        if (wr_index == rbm_pkg::RegExponent) exp_reg <= wr_data;
        else if (wr_index == rbm_pkg::RegModulus) mod_reg <= wr_data;
      end
      // accepted message word
      if (s_tvalid && s_tready)
        cipher_q.insert(cipher_q.size(), mod_power(s_tdata[W-1:0], exp_reg, mod_reg));
      // accepted cipher word
      if (m_tvalid && m_tready) begin
        if (cipher_q.size() == 0) begin
          report($sformatf("unexpected cipher word %0d", m_tdata[W-1:0]));
        end else begin
          if (m_tdata[W-1:0] !== cipher_q[0])
            report($sformatf("cipher_block got %0d want %0d",
                             m_tdata[W-1:0], cipher_q[0]));
          void'(cipher_q.pop_front());
        end
      end
    end
  end
endmodule

@@ dv/tb_rsa_block_modexp.sv @@
// testbench top of the modular exponentiation block: stimulus and verdict
`timescale 1ns / 1ps
module tb_rsa_block_modexp;
  localparam int W = rbm_pkg::DataWidth;
  localparam int Latency = 2400;
  localparam int CycleLimit = 4000000;

  logic clk;
  logic rst;
  logic wr_en;
  logic [0:0] wr_index;
  logic [W-1:0] wr_data;
  logic s_tvalid;
  logic s_tready;
  logic [rbm_pkg::TdataWidth-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [rbm_pkg::TdataWidth-1:0] m_tdata;
  int fails;
  int pending;
  int cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int sent;

  rsa_block_modexp dut (.*);

  rbm_cipher_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stalls
  always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // idling shifts with progress through the run
  function automatic void set_idling();
    if (sent < 100) begin
      tx_idle_pct = 30; rx_idle_pct = 64;
    end else if (sent < 200) begin
      tx_idle_pct = 64; rx_idle_pct = 30;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
  endfunction

  task automatic send_word(logic [W-1:0] msg);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, msg};
    do @(posedge clk); while (!s_tready);
    sent++;
    set_idling();
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // write both registers once the block has drained
  task automatic set_key(logic [W-1:0] e, logic [W-1:0] m);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    wr_en <= 1'b1; wr_index <= rbm_pkg::RegExponent; wr_data <= e;
    @(posedge clk);
    wr_index <= rbm_pkg::RegModulus; wr_data <= m;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_msg(logic [W-1:0] m);
    case ($urandom_range(3))
      0: return W'($urandom());
      1: return (m == '0) ? '0 : W'($urandom() % 32'(m));
      2: return W'($urandom_range(15));
      default: return (m == '0) ? '1 : m - W'($urandom_range(1, 2));
    endcase
  endfunction

  initial begin
    logic [W-1:0] e;
    logic [W-1:0] m;
    sent = 0;
    set_idling();
    rst = 1'b1; wr_en = 1'b0; wr_index = rbm_pkg::RegExponent; wr_data = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key: exponent one, modulus two
    send_word('0); send_word(W'(1)); send_word('1); send_word(31'h2AAA_AAAA);
    // zero exponent, largest modulus, messages below and at the modulus
    set_key('0, '1);
    send_word('0); send_word('1); send_word(31'h5555_5555); send_word(W'(7));
    // largest exponent and modulus
    set_key('1, '1);
    send_word(W'(2)); send_word(31'h7FFF_FFFE); send_word('1); send_word(31'h1234_5678);
    // common public exponent on an even modulus
    set_key(W'(65537), 31'h7FFF_FFFE);
    send_word(W'(3)); send_word('1); send_word(31'h7FFF_FFFD);
    // modulus of one, also with zero exponent
    set_key('0, W'(1));
    send_word(W'(5)); send_word('0);
    set_key(W'(3), W'(1));
    send_word('1);
    // modulus of zero
    set_key(W'(5), '0);
    send_word(W'(9)); send_word('1);
    // smallest modulus with zero exponent
    set_key('0, W'(2));
    send_word('0); send_word(W'(3));

    // random keys, mostly real-sized moduli
    while (sent < 290) begin
      m = ($urandom_range(9) == 0) ? W'($urandom_range(3))
                                   : W'($urandom_range(2, 32'h7FFF_FFFF));
      case ($urandom_range(3))
        0: e = W'($urandom_range(31));
        1: e = W'(65537);
        default: e = W'($urandom());
      endcase
      set_key(e, m);
      repeat ($urandom_range(15, 30)) send_word(rand_msg(m));
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
